FILE: src/asidl_pkg.sv
// shared field widths, request kinds and status codes of the array set
package asidl_pkg;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_MEMBER = 2'd2,
        K_READ   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_BADPOS   = 3'd5
    } status_t;

endpackage

FILE: src/asidl_ram.sv
// generic single-write, single-read ram with registered read data
module asidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/array_set_insert_delete_lookup.sv
// top level of the array-based set: request sequencer, entry ram and result register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready  | s_kind, s_value, s_position
//  m_      | out       | m_valid / m_ready  | m_status, m_found, m_read_value
//
// one transaction in gives exactly one transaction out
// insert and member query: a linear search that reads one entry per cycle from the
//   ram's single read port; insert appends at the end when the value is absent
// delete: search up to the hit then shift-down of the tail, again one entry per cycle
//   through the same read port; read by position: a single ram read issued from the port
// reset clears the count and the control state only; the entry ram needs no clearing
// a stalled result waits in the output register while the next transaction is taken

module array_set_insert_delete_lookup #(
    parameter int CAPACITY = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [asidl_pkg::KIND_W-1:0]    s_kind,
    input  logic signed [asidl_pkg::VALUE_W-1:0] s_value,
    input  logic [asidl_pkg::POS_W-1:0]     s_position,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [asidl_pkg::STATUS_W-1:0]  m_status,
    output logic                            m_found,
    output logic signed [asidl_pkg::VALUE_W-1:0] m_read_value
);

    import asidl_pkg::*;

    // address width of the ram, and count width that can also hold CAPACITY
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // common width for comparing the 8-bit position with the count
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        IDLE,
        SEARCH,
        SHIFT,
        READ,
        FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic                ready_reg, ready_next;
    logic [CW-1:0]       count_reg, count_next;

    // request held for the duration of the sequence
    kind_t               kind_reg, kind_next;
    logic [VALUE_W-1:0]  value_reg, value_next;

    // scan pointer and the read that is in flight through the ram
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [CW-1:0]       pend_idx_reg, pend_idx_next;

    // result being built
    status_t             res_status_reg, res_status_next;
    logic                res_found_reg, res_found_next;
    logic [VALUE_W-1:0]  res_data_reg, res_data_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic                m_found_reg, m_found_next;
    logic [VALUE_W-1:0]  m_data_reg, m_data_next;

    // ram port signals
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic [AW-1:0]       rd_addr;
    logic [VALUE_W-1:0]  rd_data;

    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       count_x;
    logic                issue;
    logic                hit;
    logic                load_out;

    asidl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pos_x   = XW'(s_position);
    assign count_x = XW'(count_reg);

    // next read is issued while the scan pointer is still below the count
    assign issue = (scan_idx_reg < count_reg);
    // data of last cycle's read matches the requested value
    assign hit   = pend_reg && (rd_data == value_reg);
    // result register is free, or is being emptied this cycle
    assign load_out = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_data_next   = res_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_data_next     = m_data_reg;

        wr_en   = 1'b0;
        wr_addr = AW'(pend_idx_reg - CW'(1));
        wr_data = rd_data;
        rd_addr = AW'(scan_idx_reg);

        unique case (state_reg)
            IDLE: begin
                // read by position issues its ram read straight from the port
                rd_addr = AW'(pos_x - XW'(1));
                if (s_valid && ready_reg) begin
                    kind_next       = kind_t'(s_kind);
                    value_next      = s_value;
                    scan_idx_next   = '0;
                    pend_next       = 1'b0;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    res_data_next   = '0;
                    unique case (kind_t'(s_kind))
                        K_INSERT: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                                state_next      = FINISH;
                            end else begin
                                state_next = SEARCH;
                            end
                        end
                        K_DELETE, K_MEMBER: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                state_next      = FINISH;
                            end else begin
                                state_next = SEARCH;
                            end
                        end
                        K_READ: begin
                            priority if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                state_next      = FINISH;
                            end else if (pos_x == '0 || pos_x > count_x) begin
                                res_status_next = ST_BADPOS;
                                state_next      = FINISH;
                            end else begin
                                state_next = READ;
                            end
                        end
                    endcase
                end
            end

            SEARCH: begin
                priority if (hit) begin
                    unique case (kind_reg)
                        K_INSERT: begin
                            res_status_next = ST_DUP;
                            res_found_next  = 1'b1;
                            state_next      = FINISH;
                        end
                        K_MEMBER: begin
                            res_found_next = 1'b1;
                            state_next     = FINISH;
                        end
                        default: begin
                            // delete: close the gap starting right after the hit
                            scan_idx_next = pend_idx_reg + CW'(1);
                            pend_next     = 1'b0;
                            state_next    = SHIFT;
                        end
                    endcase
                end else if (issue) begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (kind_reg == K_INSERT) begin
                        // absent: append at the end
                        wr_en      = 1'b1;
                        wr_addr    = AW'(count_reg);
                        wr_data    = value_reg;
                        count_next = count_reg + CW'(1);
                    end else begin
                        res_status_next = ST_NOTFOUND;
                    end
                    state_next = FINISH;
                end
            end

            SHIFT: begin
                // write the entry read last cycle one slot lower
                wr_en = pend_reg;
                if (issue) begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end else begin
                    pend_next      = 1'b0;
                    count_next     = count_reg - CW'(1);
                    res_found_next = 1'b1;
                    state_next     = FINISH;
                end
            end

            READ: begin
                res_data_next = rd_data;
                state_next    = FINISH;
            end

            FINISH: begin
                if (load_out) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = res_found_reg;
                    m_data_next   = res_data_reg;
                    state_next    = IDLE;
                end
            end

            default: begin
                state_next = IDLE;
            end
        endcase

        ready_next = (state_next == IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            ready_reg   <= 1'b0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ready_reg   <= ready_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_data_reg   <= res_data_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready      = ready_reg;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_read_value = m_data_reg;

endmodule

FILE: src/asidl_chk.sv
// port-level checker for the array set, bound to the top level
module asidl_chk (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic [asidl_pkg::STATUS_W-1:0]        m_status,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic                                  m_found,
    input logic signed [asidl_pkg::VALUE_W-1:0]  m_read_value
);

    import asidl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found)
            && $stable(m_read_value))
        else $error("result changed while stalled");

    // block goes busy after taking a transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after a transaction");

    // found only with ok or duplicate
    a_found_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_status == ST_OK || m_status == ST_DUP)
        else $error("found with a failing status");

    // duplicate always reports found
    a_dup_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DUP |-> m_found)
        else $error("duplicate without found");

    // read data only on a successful read by position
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_value != '0 |-> m_status == ST_OK && !m_found)
        else $error("read data on a non-read result");

endmodule

bind array_set_insert_delete_lookup asidl_chk u_asidl_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_status     (m_status),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_found      (m_found),
    .m_read_value (m_read_value)
);
